// ===== rtl/core/obrm_pkg.sv =====
package obrm_pkg;

  // Run length
  localparam int SAMPLE_BITS = 1408;
  localparam int EXTRA_BITS  = 224;
  localparam int MAX_WORDS   = 51;
  localparam int TOTAL_BITS  = SAMPLE_BITS + EXTRA_BITS;
  localparam int RUN_BITS    = (TOTAL_BITS > MAX_WORDS * 32) ? MAX_WORDS * 32 : TOTAL_BITS;
  localparam int WORD_COUNT  = (RUN_BITS + 31) / 32;
  localparam int CNT_W       = $clog2(RUN_BITS);

  // Field widths
  localparam int LEVEL_W  = 16;
  localparam int SHIFT_W  = 16;
  localparam int PHASE_W  = 32;
  localparam int WORD_W   = 32;
  localparam int WIDX_W   = 6;
  localparam int SINE_W   = 12;
  localparam int CFG_IDX_W = 2;

  // Small item queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Phase offset of 0.01 rad
  localparam logic [PHASE_W-1:0] EPS_PHASE = 32'd6835653;

  // Register reset values
  localparam logic [PHASE_W-1:0] CARRIER_STEP_RST    = 32'd3611677044;
  localparam logic [PHASE_W-1:0] SUBCARRIER_STEP_RST = 32'd192175372;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_STEP    = 2'd0,
    CFG_SUBCARRIER_STEP = 2'd1,
    CFG_SUM_MODE        = 2'd2
  } cfg_idx_t;

  // Quarter-wave sine, round(2048*sin), top entry saturated
  localparam logic signed [SINE_W-1:0] QUARTER_SINE [65] = '{
    12'sd0,    12'sd50,   12'sd100,  12'sd151,  12'sd201,  12'sd251,  12'sd301,
    12'sd350,  12'sd400,  12'sd449,  12'sd498,  12'sd546,  12'sd595,  12'sd642,
    12'sd690,  12'sd737,  12'sd784,  12'sd830,  12'sd876,  12'sd921,  12'sd965,
    12'sd1009, 12'sd1053, 12'sd1096, 12'sd1138, 12'sd1179, 12'sd1220, 12'sd1260,
    12'sd1299, 12'sd1338, 12'sd1375, 12'sd1412, 12'sd1448, 12'sd1483, 12'sd1517,
    12'sd1551, 12'sd1583, 12'sd1615, 12'sd1645, 12'sd1674, 12'sd1703, 12'sd1730,
    12'sd1757, 12'sd1782, 12'sd1806, 12'sd1829, 12'sd1851, 12'sd1872, 12'sd1892,
    12'sd1911, 12'sd1928, 12'sd1945, 12'sd1960, 12'sd1974, 12'sd1987, 12'sd1998,
    12'sd2009, 12'sd2018, 12'sd2026, 12'sd2033, 12'sd2038, 12'sd2042, 12'sd2046,
    12'sd2047, 12'sd2047
  };

  // Full-wave sine from the top 8 phase bits
  function automatic logic signed [SINE_W-1:0] sine_q11(input logic [7:0] idx);
    logic [1:0]               quad;
    logic [6:0]               addr;
    logic signed [SINE_W-1:0] v;
    quad = idx[7:6];
    addr = quad[0] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
    v    = QUARTER_SINE[addr];
    return quad[1] ? -v : v;
  endfunction

  // One classified item, ready for synthesis
  typedef struct packed {
    logic signed [LEVEL_W-1:0] luma;
    logic signed [LEVEL_W-1:0] chroma;
    logic signed [LEVEL_W-1:0] boundary;
    logic [WORD_W-1:0]         bit_mask;
    logic                      sum_mode;
    logic [PHASE_W-1:0]        carrier_step;
    logic [PHASE_W-1:0]        chroma_step;
    logic [PHASE_W-1:0]        chroma_start;
  } item_t;

endpackage

// ===== rtl/core/obrm_if.sv =====
interface obrm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [obrm_pkg::LEVEL_W-1:0] luma;
  logic signed [obrm_pkg::LEVEL_W-1:0] chroma;
  logic signed [obrm_pkg::LEVEL_W-1:0] boundary;
  logic [obrm_pkg::SHIFT_W-1:0]        chroma_phase;
  logic [obrm_pkg::WORD_W-1:0]         bit_mask;

  modport source (output valid, luma, chroma, boundary, chroma_phase, bit_mask, input ready);
  modport sink   (input valid, luma, chroma, boundary, chroma_phase, bit_mask, output ready);
endinterface

interface obrm_out_if;
  logic                        valid;
  logic                        ready;
  logic [obrm_pkg::WIDX_W-1:0] word_index;
  logic [obrm_pkg::WORD_W-1:0] word_bits;
  logic                        last_word;

  modport source (output valid, word_index, word_bits, last_word, input ready);
  modport sink   (input valid, word_index, word_bits, last_word, output ready);
endinterface

// ===== rtl/core/one_bit_rf_modulator.sv =====
// One-bit RF modulator.
// in_word carries luma, chroma and boundary levels, a subcarrier phase shift
// and a bit mask. For each accepted word the block synthesizes one symbol
// period of 1632 one-bit samples and returns them on out_word as 51 packed
// 32-bit words (first sample in bit 31, masked), indexed from 0, with
// last_word set on the final one. The caller ORs them into its table.
// cfg_we/cfg_index/cfg_data write carrier_step, subcarrier_step and
// sum_mode; write them only while no word is in flight.
// Throughput: one sample per cycle while out_word does not stall, with 32
// samples packed per output word; the sample issue counter in the back end
// sets this. A two-entry queue lets the next word start the cycle after the last
// sample of the previous one. An accepted word passes the front register and
// the queue, and its samples then run through the five-stage datapath.
// Reset restores the register defaults and empties the queue and datapath.
// When out_word stalls, the finished word holds and the datapath freezes;
// the front end and queue keep accepting until queue and front register fill.
module one_bit_rf_modulator (
  input  logic                           clk,
  input  logic                           rst_n,
  obrm_in_if.sink                        in_word,
  obrm_out_if.source                     out_word,
  input  logic                           cfg_we,
  input  logic [obrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [obrm_pkg::PHASE_W-1:0]   cfg_data
);
  import obrm_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  obrm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  obrm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  obrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_word  (out_word)
  );

`ifndef SYNTH
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> out_word.word_index <= WIDX_W'(WORD_COUNT - 1))
    else $error("word index past end of run");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.last_word |-> out_word.word_index == WIDX_W'(WORD_COUNT - 1))
    else $error("last word flagged early");

  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && !out_word.last_word |-> out_word.word_index != WIDX_W'(WORD_COUNT - 1))
    else $error("final word not flagged last");

  a_queue_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_ready |=> push_valid)
    else $error("front dropped a classified word");
`endif

endmodule

// ===== rtl/core/obrm_front.sv =====
module obrm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  obrm_in_if.sink                          in_word,
  input  logic                             cfg_we,
  input  logic [obrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [obrm_pkg::PHASE_W-1:0]     cfg_data,
  output logic                             push_valid,
  input  logic                             push_ready,
  output obrm_pkg::item_t                  push_item
);
  import obrm_pkg::*;

  logic [PHASE_W-1:0] carrier_step_r, carrier_step_nxt;
  logic [PHASE_W-1:0] subcarrier_step_r, subcarrier_step_nxt;
  logic               sum_mode_r, sum_mode_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  item_t              hold_item_r, hold_item_nxt;
  logic               accept;

  assign in_word.ready = !hold_valid_r || push_ready;
  assign accept        = in_word.valid && in_word.ready;
  assign push_valid    = hold_valid_r;
  assign push_item     = hold_item_r;

  // Decode register writes
  always_comb begin
    carrier_step_nxt    = carrier_step_r;
    subcarrier_step_nxt = subcarrier_step_r;
    sum_mode_nxt        = sum_mode_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CARRIER_STEP:    carrier_step_nxt    = cfg_data;
        CFG_SUBCARRIER_STEP: subcarrier_step_nxt = cfg_data;
        CFG_SUM_MODE:        sum_mode_nxt        = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the word: pick the chroma step and the start phase
  always_comb begin
    hold_item_nxt  = hold_item_r;
    hold_valid_nxt = hold_valid_r && !push_ready;
    if (accept) begin
      hold_valid_nxt             = 1'b1;
      hold_item_nxt.luma         = in_word.luma;
      hold_item_nxt.chroma       = in_word.chroma;
      hold_item_nxt.boundary     = in_word.boundary;
      hold_item_nxt.bit_mask     = in_word.bit_mask;
      hold_item_nxt.sum_mode     = sum_mode_r;
      hold_item_nxt.carrier_step = carrier_step_r;
      hold_item_nxt.chroma_step  = sum_mode_r ? (carrier_step_r + subcarrier_step_r)
                                              : subcarrier_step_r;
      hold_item_nxt.chroma_start = EPS_PHASE + {in_word.chroma_phase, 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_step_r    <= CARRIER_STEP_RST;
      subcarrier_step_r <= SUBCARRIER_STEP_RST;
      sum_mode_r        <= 1'b0;
      hold_valid_r      <= 1'b0;
    end else begin
      carrier_step_r    <= carrier_step_nxt;
      subcarrier_step_r <= subcarrier_step_nxt;
      sum_mode_r        <= sum_mode_nxt;
      hold_valid_r      <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_item_r <= hold_item_nxt;
  end

endmodule

// ===== rtl/core/obrm_queue.sv =====
module obrm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  obrm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output obrm_pkg::item_t pop_item
);
  import obrm_pkg::*;

  item_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/obrm_back.sv =====
module obrm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  obrm_pkg::item_t pop_item,
  obrm_out_if.source      out_word
);
  import obrm_pkg::*;

  localparam int PROD_W = 2 * SINE_W + LEVEL_W - 12;  // sine times level
  localparam int SUM_W  = PROD_W + 2;
  localparam int ACC_W  = SINE_W + SUM_W + 1;

  // Per-sample tag that rides along the pipeline
  typedef struct packed {
    logic                      sum_mode;
    logic signed [LEVEL_W-1:0] luma;
    logic signed [LEVEL_W-1:0] chroma;
    logic signed [LEVEL_W-1:0] boundary;
    logic [WORD_W-1:0]         bit_mask;
    logic [4:0]                bit_pos;
    logic [WIDX_W-1:0]         word_idx;
    logic                      word_end;
    logic                      last;
  } tag_t;

  // Issue state
  logic               busy_r, busy_nxt;
  item_t              cur_r, cur_nxt;
  logic [PHASE_W-1:0] cph_r, cph_nxt;
  logic [PHASE_W-1:0] sph_r, sph_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               last_sample;
  logic               adv;

  // Stage A: sines
  logic                     a_valid_r;
  tag_t                     a_tag_r, a_tag_nxt;
  logic signed [SINE_W-1:0] a_m_r, a_c_r;

  // Stage B: level products
  logic                     b_valid_r;
  tag_t                     b_tag_r;
  logic signed [SINE_W-1:0] b_m_r;
  logic signed [PROD_W-1:0] b_pc_r, b_pm_r;

  // Stage C: sums
  logic                     c_valid_r;
  tag_t                     c_tag_r;
  logic signed [SINE_W-1:0] c_m_r;
  logic signed [SUM_W-1:0]  c_sum_r, c_sum_nxt;

  // Stage D: carrier product in mode 0, sum passed through in mode 1
  logic                     d_valid_r;
  tag_t                     d_tag_r;
  logic signed [ACC_W-1:0]  d_val_r, d_val_nxt;

  // Stage E: sign and packing
  logic signed [ACC_W-1:0]  e_bnd;
  logic signed [ACC_W-1:0]  e_sum;
  logic                     e_bit;
  logic [WORD_W-1:0]        e_word;
  logic [WORD_W-1:0]        acc_r, acc_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [WIDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [WORD_W-1:0]  out_bits_r, out_bits_nxt;
  logic               out_last_r, out_last_nxt;

  // Hold the whole pipeline while a finished word waits
  assign adv         = !(out_valid_r && !out_word.ready);
  assign last_sample = (n_r == CNT_W'(RUN_BITS - 1));
  assign pop_ready   = adv && (!busy_r || last_sample);

  // Issue one sample per cycle unless the pipeline is held, load the next item right after the last sample
  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    cph_nxt  = cph_r;
    sph_nxt  = sph_r;
    n_nxt    = n_r;
    if (adv) begin
      if (busy_r) begin
        cph_nxt = cph_r + cur_r.carrier_step;
        sph_nxt = sph_r + cur_r.chroma_step;
        n_nxt   = n_r + 1'b1;
      end
      if (pop_ready) begin
        busy_nxt = pop_valid;
        if (pop_valid) begin
          cur_nxt = pop_item;
          cph_nxt = EPS_PHASE;
          sph_nxt = pop_item.chroma_start;
          n_nxt   = '0;
        end
      end
    end
  end

  // Tag the sample being issued
  always_comb begin
    a_tag_nxt.sum_mode = cur_r.sum_mode;
    a_tag_nxt.luma     = cur_r.luma;
    a_tag_nxt.chroma   = cur_r.chroma;
    a_tag_nxt.boundary = cur_r.boundary;
    a_tag_nxt.bit_mask = cur_r.bit_mask;
    a_tag_nxt.bit_pos  = n_r[4:0];
    a_tag_nxt.word_idx = WIDX_W'(n_r >> 5);
    a_tag_nxt.word_end = (n_r[4:0] == 5'd31) || last_sample;
    a_tag_nxt.last     = last_sample;
  end

  // Form the stage C sum: the pre-product sum in mode 0, the full sum in mode 1
  always_comb begin
    if (b_tag_r.sum_mode) begin
      c_sum_nxt = SUM_W'(b_pm_r) + SUM_W'(b_pc_r) + (SUM_W'(b_tag_r.boundary) <<< 11);
    end else begin
      c_sum_nxt = SUM_W'(b_pc_r) + (SUM_W'(b_tag_r.luma) <<< 11);
    end
  end

  // Mode 0 scales by the carrier here; mode 1 is already complete
  always_comb begin
    if (c_tag_r.sum_mode) begin
      d_val_nxt = ACC_W'(c_sum_r);
    end else begin
      d_val_nxt = ACC_W'(c_m_r) * ACC_W'(c_sum_r);
    end
  end

  // Add the boundary in mode 0, slice the sign and pack MSB-first
  always_comb begin
    e_bnd   = d_tag_r.sum_mode ? '0 : (ACC_W'(d_tag_r.boundary) <<< 22);
    e_sum   = d_val_r + e_bnd;
    e_bit   = !e_sum[ACC_W-1] && (e_sum != '0);
    e_word  = ((d_tag_r.bit_pos == 5'd0) ? '0 : acc_r)
              | (WORD_W'(e_bit) << (5'd31 - d_tag_r.bit_pos));
    acc_nxt = (adv && d_valid_r) ? e_word : acc_r;
  end

  // Load a finished word, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_idx_nxt   = out_idx_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    if (adv && d_valid_r && d_tag_r.word_end) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = d_tag_r.word_idx;
      out_bits_nxt  = e_word & d_tag_r.bit_mask;
      out_last_nxt  = d_tag_r.last;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.word_index = out_idx_r;
  assign out_word.word_bits  = out_bits_r;
  assign out_word.last_word  = out_last_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        a_valid_r <= busy_r;
        b_valid_r <= a_valid_r;
        c_valid_r <= b_valid_r;
        d_valid_r <= c_valid_r;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cph_r      <= cph_nxt;
    sph_r      <= sph_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    out_idx_r  <= out_idx_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
    if (adv) begin
      a_tag_r <= a_tag_nxt;
      a_m_r   <= sine_q11(cph_r[PHASE_W-1 -: 8]);
      a_c_r   <= sine_q11(sph_r[PHASE_W-1 -: 8]);
      b_tag_r <= a_tag_r;
      b_m_r   <= a_m_r;
      b_pc_r  <= PROD_W'(a_c_r) * PROD_W'(a_tag_r.chroma);
      b_pm_r  <= PROD_W'(a_m_r) * PROD_W'(a_tag_r.luma);
      c_tag_r <= b_tag_r;
      c_m_r   <= b_m_r;
      c_sum_r <= c_sum_nxt;
      d_tag_r <= c_tag_r;
      d_val_r <= d_val_nxt;
    end
  end

endmodule

// ===== verif/one_bit_rf_modulator_tb.sv =====
module one_bit_rf_modulator_tb;
  import obrm_pkg::*;

  localparam logic [31:0] PHASE_NUDGE   = 32'd6835653;
  localparam int          HOLD_CYCLES   = 3000;
  localparam int          DRAIN_CYCLES  = 64;
  localparam int          STALL_LIMIT   = 20000;
  localparam int          RAND_PER_SET  = 56;
  localparam int          PRINT_LIMIT   = 50;

  // Quarter-wave sine in Q1.11, top entry held at 2047
  localparam int QTR_SINE [65] = '{
    0, 50, 100, 151, 201, 251, 301, 350, 400, 449, 498, 546, 595,
    642, 690, 737, 784, 830, 876, 921, 965, 1009, 1053, 1096, 1138,
    1179, 1220, 1260, 1299, 1338, 1375, 1412, 1448, 1483, 1517, 1551,
    1583, 1615, 1645, 1674, 1703, 1730, 1757, 1782, 1806, 1829, 1851,
    1872, 1892, 1911, 1928, 1945, 1960, 1974, 1987, 1998, 2009, 2018,
    2026, 2033, 2038, 2042, 2046, 2047, 2047
  };

  typedef struct packed {
    logic signed [15:0] luma;
    logic signed [15:0] chroma;
    logic signed [15:0] boundary;
    logic [15:0]        chroma_phase;
    logic [31:0]        bit_mask;
  } symbol_t;

  typedef struct packed {
    logic [5:0]  word_index;
    logic [31:0] word_bits;
    logic        last_word;
  } packed_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  obrm_in_if  in_ch ();
  obrm_out_if out_ch ();

  one_bit_rf_modulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_ch),
    .out_word  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the configuration registers
  logic [31:0] carrier_step_q;
  logic [31:0] subcarrier_step_q;
  logic        sum_mode_q;

  symbol_t      pending_symbols [$];
  packed_word_t expected_words [$];

  logic in_taken = 1'b0;
  logic quiet = 1'b0;
  int   symbols_taken = 0;
  int   err_cnt = 0;
  int   hold_ask = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_cnt = 0;

  always #2 clk = ~clk;

  // Full-wave sine from the top 8 phase bits
  function automatic int sine_lookup(input logic [31:0] ph);
    logic [1:0] quad;
    logic [5:0] r;
    int         v;
    quad = ph[31:30];
    r    = ph[29:24];
    v    = quad[0] ? QTR_SINE[64 - r] : QTR_SINE[r];
    return quad[1] ? -v : v;
  endfunction

  // Synthesize one symbol period and queue the masked sign words
  function automatic void synth_symbol(input symbol_t sym);
    logic [31:0]  cph;
    logic [31:0]  sph;
    logic [31:0]  inc;
    logic [31:0]  bits;
    longint       m;
    longint       c;
    longint       s;
    int           n;
    packed_word_t w;
    n   = 0;
    inc = sum_mode_q ? (carrier_step_q + subcarrier_step_q) : subcarrier_step_q;
    cph = PHASE_NUDGE;
    sph = PHASE_NUDGE + {sym.chroma_phase, 16'h0000};
    for (int wi = 0; wi < WORD_COUNT; wi++) begin
      bits = '0;
      for (int b = 0; b < 32; b++) begin
        if (n < TOTAL_BITS) begin
          m = sine_lookup(cph);
          c = sine_lookup(sph);
          if (sum_mode_q)
            s = m * longint'(sym.luma) + c * longint'(sym.chroma) +
                longint'(sym.boundary) * 2048;
          else
            s = m * (c * longint'(sym.chroma) + longint'(sym.luma) * 2048) +
                longint'(sym.boundary) * 4194304;
          if (s > 0) bits[31-b] = 1'b1;
          cph = cph + carrier_step_q;
          sph = sph + inc;
          n++;
        end
      end
      w.word_index = wi[5:0];
      w.word_bits  = bits & sym.bit_mask;
      w.last_word  = (wi == WORD_COUNT - 1);
      expected_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_cnt < PRINT_LIMIT)
      $display("mismatch %s: expected %h got %h", what, want, got);
    err_cnt++;
  endtask

  // Check finished words, then predict newly accepted symbols
  always @(posedge clk) begin : scoreboard
    packed_word_t e;
    symbol_t      sym;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 32'h0, out_ch.word_bits);
        end else begin
          e = expected_words.pop_front();
          if (out_ch.word_index !== e.word_index)
            report_mismatch("word_index", 32'(e.word_index), 32'(out_ch.word_index));
          if (out_ch.word_bits !== e.word_bits)
            report_mismatch("word_bits", e.word_bits, out_ch.word_bits);
          if (out_ch.last_word !== e.last_word)
            report_mismatch("last_word", 32'(e.last_word), 32'(out_ch.last_word));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        sym.luma         = in_ch.luma;
        sym.chroma       = in_ch.chroma;
        sym.boundary     = in_ch.boundary;
        sym.chroma_phase = in_ch.chroma_phase;
        sym.bit_mask     = in_ch.bit_mask;
        synth_symbol(sym);
        symbols_taken++;
      end
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Offer pending symbols, idling now and then
  always @(negedge clk) begin : feeder
    symbol_t sym;
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (pending_symbols.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
          sym = pending_symbols.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.luma         <= sym.luma;
          in_ch.chroma       <= sym.chroma;
          in_ch.boundary     <= sym.boundary;
          in_ch.chroma_phase <= sym.chroma_phase;
          in_ch.bit_mask     <= sym.bit_mask;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Drive ready: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : drain
    if (rst_n) begin
      if (hold_seen != hold_ask) begin
        hold_seen    <= hold_ask;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 13);
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", stall_cnt);
        $display("** one_bit_rf_modulator: FAILED **");
        $finish;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_CARRIER_STEP:    carrier_step_q = val;
      CFG_SUBCARRIER_STEP: subcarrier_step_q = val;
      CFG_SUM_MODE:        sum_mode_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_all(input logic [31:0] car, input logic [31:0] sub, input logic mode);
    cfg_write(CFG_CARRIER_STEP, car);
    cfg_write(CFG_SUBCARRIER_STEP, sub);
    cfg_write(CFG_SUM_MODE, {31'd0, mode});
  endtask

  // Hold until no symbol is queued, in flight or owed, then let the pipe settle
  task automatic wait_drained();
    while (pending_symbols.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_symbol(input logic [15:0] l, input logic [15:0] c,
                            input logic [15:0] b, input logic [15:0] p,
                            input logic [31:0] m);
    symbol_t sym;
    sym.luma         = l;
    sym.chroma       = c;
    sym.boundary     = b;
    sym.chroma_phase = p;
    sym.bit_mask     = m;
    pending_symbols.push_back(sym);
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1, 2:    return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_directed();
    add_symbol(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hffff_ffff);
    add_symbol(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 32'hffff_ffff);
    add_symbol(16'h8000, 16'h0000, 16'h0000, 16'h0000, 32'hffff_ffff);
    add_symbol(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 32'hffff_ffff);
    add_symbol(16'h0000, 16'h8000, 16'h0000, 16'hffff, 32'hffff_ffff);
    add_symbol(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 32'hffff_ffff);
    add_symbol(16'h0000, 16'h0000, 16'h8000, 16'h0000, 32'hffff_ffff);
    add_symbol(16'h1000, 16'h2000, 16'hf800, 16'h4000, 32'haaaa_aaaa);
    add_symbol(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 32'h5555_5555);
    add_symbol(16'h8000, 16'h8000, 16'h8000, 16'hffff, 32'h0000_0000);
    add_symbol(16'h0001, 16'hffff, 16'h0000, 16'h0001, 32'h8000_0001);
    add_symbol(16'hffff, 16'h0001, 16'h0001, 16'hc000, 32'hffff_0000);
  endtask

  task automatic add_random(input int count);
    for (int i = 0; i < count; i++)
      add_symbol(pick_level(), pick_level(), pick_level(), 16'($urandom), pick_mask());
  endtask

  initial begin : main
    int base;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_CARRIER_STEP;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.luma         = '0;
    in_ch.chroma       = '0;
    in_ch.boundary     = '0;
    in_ch.chroma_phase = '0;
    in_ch.bit_mask     = '0;
    out_ch.ready       = 1'b0;
    carrier_step_q     = CARRIER_STEP_RST;
    subcarrier_step_q  = SUBCARRIER_STEP_RST;
    sum_mode_q         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      quiet = 1'b0;
      wait_drained();
      // Step through register settings, extremes included
      case (ph)
        0: ;
        1: cfg_all(CARRIER_STEP_RST, SUBCARRIER_STEP_RST, 1'b1);
        2: cfg_all(32'h0000_0000, 32'hffff_ffff, 1'b0);
        3: cfg_all(32'hffff_ffff, 32'h0000_0000, 1'b1);
        4: cfg_all($urandom, $urandom, 1'b0);
        5: cfg_all(CARRIER_STEP_RST, SUBCARRIER_STEP_RST, 1'b1);
        6: cfg_all($urandom, $urandom, 1'b0);
        default: cfg_all(32'hffff_ffff, 32'hffff_ffff, 1'b1);
      endcase
      if (ph == 4) quiet = 1'b1;
      @(posedge clk);
      base = symbols_taken;
      if (ph < 2) add_directed();
      else add_random(RAND_PER_SET);
      // Stall the output long enough for the input to back up
      if (ph == 5) begin
        while (symbols_taken < base + 2) @(posedge clk);
        hold_ask = hold_ask + 1;
      end
    end

    quiet = 1'b0;
    wait_drained();
    if (expected_words.size() != 0)
      report_mismatch("words never returned", 32'(expected_words.size()), 32'h0);
    if (err_cnt == 0)
      $display("** one_bit_rf_modulator: PASSED **");
    else
      $display("** one_bit_rf_modulator: FAILED **");
    $finish;
  end

endmodule
